[sv/dhbd_pkg.sv]
// Shared types, constants and table builder for the detection head box decoder.
package dhbd_pkg;

    localparam int unsigned MAX_CLASSES             = 255;
    localparam int unsigned ANCHORS_PER_CELL        = 3;
    localparam int unsigned MAX_GRID                = 160;
    localparam int unsigned SIGMOID_TABLE_BITS_DEF  = 10;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 60;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CONF_THRESHOLD = 3'd0,
        CFG_GRID_SIZE      = 3'd1,
        CFG_CLASS_COUNT    = 3'd2,
        CFG_GRID_STRIDE    = 3'd3,
        CFG_ANCHOR_SIZES   = 3'd4,
        CFG_PAD_LEFT       = 3'd5,
        CFG_PAD_TOP        = 3'd6,
        CFG_INVERSE_SCALE  = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_APPLY,
        ST_CONF,
        ST_DECIDE,
        ST_D1,
        ST_D2,
        ST_D3,
        ST_D4
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic look;
        logic apply;
        logic conf;
        logic decide;
        logic d1;
        logic d2;
        logic d3;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last;
        logic pass;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
        logic [15:0]        confidence;
        logic [7:0]         class_index;
    } box_t;

    // Restoring division, evaluated only while building the sigmoid table.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sigmoid at the lower edge of bin k; sh = 14 - table bits.
    function automatic logic [15:0] sig_entry(input int unsigned k, input int unsigned sh);
        int          p;
        logic [63:0] a;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] q;
        p = int'(k << sh) - 8192;
        a = (p < 0) ? 64'(-p) : 64'(p);
        e = (64'd1 << 31) - (a << 3);
        for (int i = 0; i < 20; i++) begin
            e = (e * e + (64'd1 << 30)) >> 31;
        end
        d   = (64'd1 << 31) + e;
        num = (p >= 0) ? ((64'd1 << 47) + (d >> 1)) : ((e << 16) + (d >> 1));
        q   = udiv64(num, d);
        return (q > 64'd65535) ? 16'hFFFF : q[15:0];
    endfunction

endpackage

[sv/dhbd_if.sv]
// Channel interfaces: head logits in, boxes out, configuration writes.
interface dhbd_head_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] logit;
    logic               map_start;

    modport source (output valid, output logit, output map_start, input ready);
    modport sink   (input valid, input logit, input map_start, output ready);
endinterface

interface dhbd_box_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic [15:0]        box_width;
    logic [15:0]        box_height;
    logic [15:0]        confidence;
    logic [7:0]         class_index;

    modport source (output valid, output box_left, output box_top, output box_width,
                    output box_height, output confidence, output class_index, input ready);
    modport sink   (input valid, input box_left, input box_top, input box_width,
                    input box_height, input confidence, input class_index, output ready);
endinterface

interface dhbd_cfg_if import dhbd_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/dhbd_ctrl.sv]
// Sequencer for lookup, field update, confidence, threshold test and box decode steps.
module dhbd_ctrl import dhbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t sts,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = sts.last ? ST_CONF : ST_IDLE;
            end
            ST_CONF:
            begin
                cmd.conf   = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = sts.pass ? ST_D1 : ST_IDLE;
            end
            ST_D1:
            begin
                cmd.d1     = 1'b1;
                state_next = ST_D2;
            end
            ST_D2:
            begin
                cmd.d2     = 1'b1;
                state_next = ST_D3;
            end
            ST_D3:
            begin
                cmd.d3     = 1'b1;
                state_next = ST_D4;
            end
            ST_D4:
            begin
                // hold until the output word slot frees up
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/dhbd_dp.sv]
// Datapath: config registers, sigmoid ROM, cell counters, decode stages, output word.
module dhbd_dp import dhbd_pkg::*;
#(
    parameter int unsigned SIGMOID_TABLE_BITS = SIGMOID_TABLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic signed [15:0]     logit,
    input  logic                   map_start,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             sts,
    output logic                   out_valid,
    input  logic                   out_ready,
    output box_t                   box
);

    localparam int unsigned SIG_SH    = 14 - SIGMOID_TABLE_BITS;
    localparam int unsigned SIG_DEPTH = 1 << SIGMOID_TABLE_BITS;

    typedef logic [15:0] sig_rom_t [SIG_DEPTH];

    function automatic sig_rom_t build_rom();
        sig_rom_t r;
        for (int k = 0; k < SIG_DEPTH; k++) begin
            r[k] = sig_entry(k, SIG_SH);
        end
        return r;
    endfunction

    localparam sig_rom_t SIG_ROM = build_rom();

    // configuration
    logic [15:0] thr_reg;
    logic [7:0]  grid_reg;
    logic [7:0]  ncls_reg;
    logic [6:0]  stride_reg;
    logic [59:0] anchors_reg;
    logic [9:0]  padl_reg;
    logic [9:0]  padt_reg;
    logic [23:0] inv_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            thr_reg     <= 16'd16384;
            grid_reg    <= 8'd80;
            ncls_reg    <= 8'd80;
            stride_reg  <= 7'd8;
            anchors_reg <= '0;
            padl_reg    <= '0;
            padt_reg    <= '0;
            inv_reg     <= 24'd65536;
        end
        else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_CONF_THRESHOLD: thr_reg     <= cfg_data[15:0];
                CFG_GRID_SIZE:      grid_reg    <= cfg_data[7:0];
                CFG_CLASS_COUNT:    ncls_reg    <= cfg_data[7:0];
                CFG_GRID_STRIDE:    stride_reg  <= cfg_data[6:0];
                CFG_ANCHOR_SIZES:   anchors_reg <= cfg_data[59:0];
                CFG_PAD_LEFT:       padl_reg    <= cfg_data[9:0];
                CFG_PAD_TOP:        padt_reg    <= cfg_data[9:0];
                CFG_INVERSE_SCALE:  inv_reg     <= cfg_data[23:0];
                default:            thr_reg     <= thr_reg;
            endcase
        end
    end

    // clamped config
    logic [8:0] ncls_eff;
    logic [8:0] grid_eff;
    assign ncls_eff = (ncls_reg > 8'(MAX_CLASSES)) ? 9'(MAX_CLASSES) : {1'b0, ncls_reg};
    assign grid_eff = (grid_reg == 8'd0)            ? 9'd1 :
                      ({1'b0, grid_reg} > 9'(MAX_GRID)) ? 9'(MAX_GRID) : {1'b0, grid_reg};

    // item capture and counters
    logic signed [15:0] logit_reg;
    logic [8:0]         field_reg;
    logic [7:0]         col_reg;
    logic [7:0]         row_reg;
    logic [1:0]         anc_reg;

    logic [7:0] col_s_reg;
    logic [7:0] row_s_reg;
    logic [1:0] anc_s_reg;

    logic       last;
    logic [8:0] col_inc;
    logic [8:0] row_inc;
    logic [2:0] anc_inc;

    assign last    = field_reg >= (9'd4 + ncls_eff);
    assign col_inc = {1'b0, col_reg} + 9'd1;
    assign row_inc = {1'b0, row_reg} + 9'd1;
    assign anc_inc = {1'b0, anc_reg} + 3'd1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            field_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            anc_reg   <= '0;
        end
        else begin
            if (cmd.accept && map_start) begin
                field_reg <= '0;
                col_reg   <= '0;
                row_reg   <= '0;
                anc_reg   <= '0;
            end
            if (cmd.apply) begin
                field_reg <= last ? 9'd0 : field_reg + 9'd1;
            end
            if (cmd.decide) begin
                if (col_inc >= grid_eff) begin
                    col_reg <= '0;
                    if (row_inc >= grid_eff) begin
                        row_reg <= '0;
                        anc_reg <= (anc_inc >= 3'(ANCHORS_PER_CELL)) ? 2'd0 : anc_inc[1:0];
                    end
                    else begin
                        row_reg <= row_inc[7:0];
                    end
                end
                else begin
                    col_reg <= col_inc[7:0];
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.accept) begin
            logit_reg <= logit;
        end
        if (cmd.decide) begin
            col_s_reg <= col_reg;
            row_s_reg <= row_reg;
            anc_s_reg <= anc_reg;
        end
    end

    // sigmoid lookup
    logic [13:0]                   sig_u;
    logic [SIGMOID_TABLE_BITS-1:0] sig_addr;
    logic [15:0]                   sig_reg;

    always_comb begin
        if (logit_reg < -16'sd8192) begin
            sig_u = 14'd0;
        end
        else if (logit_reg > 16'sd8191) begin
            sig_u = 14'h3FFF;
        end
        else begin
            sig_u = 14'(logit_reg + 16'sd8192);
        end
    end
    assign sig_addr = sig_u[13:SIG_SH];

    always_ff @(posedge clk) begin
        if (cmd.look) begin
            sig_reg <= SIG_ROM[sig_addr];
        end
    end

    // field update: box sigmoids, objectness, running class max
    logic [15:0] box_sig_reg [4];
    logic [15:0] obj_reg;
    logic [15:0] best_reg;
    logic [7:0]  idx_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            // a zero logit maps to the middle table entry
            for (int i = 0; i < 4; i++) begin
                box_sig_reg[i] <= SIG_ROM[SIG_DEPTH/2];
            end
            obj_reg  <= '0;
            best_reg <= '0;
            idx_reg  <= '0;
        end
        else if (cmd.apply) begin
            if (field_reg < 9'd4) begin
                box_sig_reg[field_reg[1:0]] <= sig_reg;
            end
            else if (field_reg == 9'd4) begin
                obj_reg  <= sig_reg;
                best_reg <= '0;
                idx_reg  <= '0;
            end
            else if (sig_reg > best_reg) begin
                best_reg <= sig_reg;
                idx_reg  <= 8'(field_reg - 9'd5);
            end
        end
    end

    // confidence
    logic [31:0] conf_prod;
    logic [15:0] conf_reg;
    assign conf_prod = obj_reg * best_reg;

    always_ff @(posedge clk) begin
        if (cmd.conf) begin
            conf_reg <= conf_prod[31:16];
        end
    end

    // decode stage 1: grid centre and squared size terms
    logic signed [25:0] sx_term;
    logic signed [25:0] sy_term;
    logic signed [33:0] qx_reg;
    logic signed [33:0] qy_reg;
    logic [33:0]        w2_reg;
    logic [33:0]        h2_reg;
    logic signed [7:0]  stride_s;

    assign stride_s = $signed({1'b0, stride_reg});
    assign sx_term  = $signed({9'd0, box_sig_reg[0], 1'b0}) - 26'sd32768
                    + $signed({2'b0, col_s_reg, 16'd0});
    assign sy_term  = $signed({9'd0, box_sig_reg[1], 1'b0}) - 26'sd32768
                    + $signed({2'b0, row_s_reg, 16'd0});

    always_ff @(posedge clk) begin
        if (cmd.d1) begin
            qx_reg <= sx_term * stride_s;
            qy_reg <= sy_term * stride_s;
            w2_reg <= {1'b0, box_sig_reg[2], 1'b0} * {1'b0, box_sig_reg[2], 1'b0};
            h2_reg <= {1'b0, box_sig_reg[3], 1'b0} * {1'b0, box_sig_reg[3], 1'b0};
        end
    end

    // decode stage 2: truncate centre, remove padding; scale by anchor
    logic [9:0] anc_w;
    logic [9:0] anc_h;

    always_comb begin
        unique case (anc_s_reg)
            2'd0:
            begin
                anc_w = anchors_reg[9:0];
                anc_h = anchors_reg[19:10];
            end
            2'd1:
            begin
                anc_w = anchors_reg[29:20];
                anc_h = anchors_reg[39:30];
            end
            2'd2:
            begin
                anc_w = anchors_reg[49:40];
                anc_h = anchors_reg[59:50];
            end
            default:
            begin
                anc_w = '0;
                anc_h = '0;
            end
        endcase
    end

    logic [33:0]        qx_mag;
    logic [33:0]        qy_mag;
    logic signed [18:0] cx;
    logic signed [18:0] cy;
    logic signed [19:0] dx_reg;
    logic signed [19:0] dy_reg;
    logic [27:0]        wq_reg;
    logic [27:0]        hq_reg;

    assign qx_mag = qx_reg[33] ? 34'(-qx_reg) : 34'(qx_reg);
    assign qy_mag = qy_reg[33] ? 34'(-qy_reg) : 34'(qy_reg);
    assign cx = qx_reg[33] ? -$signed({1'b0, qx_mag[33:16]}) : $signed({1'b0, qx_mag[33:16]});
    assign cy = qy_reg[33] ? -$signed({1'b0, qy_mag[33:16]}) : $signed({1'b0, qy_mag[33:16]});

    always_ff @(posedge clk) begin
        if (cmd.d2) begin
            dx_reg <= $signed({cx[18], cx}) - $signed({10'd0, padl_reg});
            dy_reg <= $signed({cy[18], cy}) - $signed({10'd0, padt_reg});
            wq_reg <= w2_reg[33:16] * anc_w;
            hq_reg <= h2_reg[33:16] * anc_h;
        end
    end

    // decode stage 3: undo letterbox scale
    logic signed [24:0] inv_s;
    logic signed [44:0] px_reg;
    logic signed [44:0] py_reg;
    logic [35:0]        pw_reg;
    logic [35:0]        ph_reg;

    assign inv_s = $signed({1'b0, inv_reg});

    always_ff @(posedge clk) begin
        if (cmd.d3) begin
            px_reg <= dx_reg * inv_s;
            py_reg <= dy_reg * inv_s;
            pw_reg <= wq_reg[27:16] * inv_reg;
            ph_reg <= hq_reg[27:16] * inv_reg;
        end
    end

    // decode stage 4: corners and saturation
    logic [44:0]        px_mag;
    logic [44:0]        py_mag;
    logic signed [29:0] bx;
    logic signed [29:0] by;
    logic [19:0]        bw;
    logic [19:0]        bh;
    logic signed [30:0] left_full;
    logic signed [30:0] top_full;
    box_t               box_next;

    assign px_mag = px_reg[44] ? 45'(-px_reg) : 45'(px_reg);
    assign py_mag = py_reg[44] ? 45'(-py_reg) : 45'(py_reg);
    assign bx = px_reg[44] ? -$signed({1'b0, px_mag[44:16]}) : $signed({1'b0, px_mag[44:16]});
    assign by = py_reg[44] ? -$signed({1'b0, py_mag[44:16]}) : $signed({1'b0, py_mag[44:16]});
    assign bw = pw_reg[35:16];
    assign bh = ph_reg[35:16];
    assign left_full = $signed({bx[29], bx}) - $signed({12'd0, bw[19:1]});
    assign top_full  = $signed({by[29], by}) - $signed({12'd0, bh[19:1]});

    always_comb begin
        if (left_full < -31'sd32768) begin
            box_next.box_left = 16'sh8000;
        end
        else if (left_full > 31'sd32767) begin
            box_next.box_left = 16'sh7FFF;
        end
        else begin
            box_next.box_left = left_full[15:0];
        end
        if (top_full < -31'sd32768) begin
            box_next.box_top = 16'sh8000;
        end
        else if (top_full > 31'sd32767) begin
            box_next.box_top = 16'sh7FFF;
        end
        else begin
            box_next.box_top = top_full[15:0];
        end
        box_next.box_width   = (bw > 20'd65535) ? 16'hFFFF : bw[15:0];
        box_next.box_height  = (bh > 20'd65535) ? 16'hFFFF : bh[15:0];
        box_next.confidence  = conf_reg;
        box_next.class_index = idx_reg;
    end

    // output word register
    logic out_valid_reg;
    box_t box_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            box_reg <= box_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign box          = box_reg;
    assign sts.last     = last;
    assign sts.pass     = (obj_reg >= thr_reg) && (conf_reg >= thr_reg);
    assign sts.out_free = !out_valid_reg || out_ready;

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        field_reg <= 9'(4 + MAX_CLASSES))
        else $error("field counter ran past the last class field");

    assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < 8'(MAX_GRID))
        else $error("column counter outside the grid");

    assert property (@(posedge clk) disable iff (!rst_n)
        anc_reg < 2'(ANCHORS_PER_CELL))
        else $error("anchor counter out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten before it was taken");

endmodule

[sv/detection_head_box_decode_core.sv]
// Detection head box decoder: one head logit per word in, zero or one box per anchor of a cell out.
// Steps: a field word is accepted, read through the sigmoid ROM and applied as a field
//   update; the last field of an anchor's prediction adds the confidence product and the
//   threshold test and, when a box is produced, decode steps D1 to D4, the last of them
//   loading the output word; a full output slot holds the sequencer in the load step.
//   A new word is taken only once the sequencer is back in idle, after all steps of the
//   last one. rst_n clears config to defaults, counters to 0.
module detection_head_box_decode_core import dhbd_pkg::*;
#(
    parameter int unsigned SIGMOID_TABLE_BITS = SIGMOID_TABLE_BITS_DEF
)
(
    input logic          clk,
    input logic          rst_n,
    dhbd_head_if.sink    head,
    dhbd_box_if.source   boxes,
    dhbd_cfg_if.sink     cfg
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;
    box_t       box;
    logic       in_ready;
    logic       out_valid;

    // Config writes always taken; source must write only while nothing is in flight, unenforced.
    assign cfg.ready  = 1'b1;
    assign head.ready = in_ready;

    // Sequencer: one state per step, ready only when waiting for a new word.
    dhbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (head.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: config, sigmoid table, cell tracking, decode math, output word.
    dhbd_dp #(
        .SIGMOID_TABLE_BITS (SIGMOID_TABLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .logit     (head.logit),
        .map_start (head.map_start),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (boxes.ready),
        .box       (box)
    );

    // Output word is registered inside the datapath, so new logits keep flowing while a
    // finished box waits for the sink, until the next box is held in the load step.
    assign boxes.valid       = out_valid;
    assign boxes.box_left    = box.box_left;
    assign boxes.box_top     = box.box_top;
    assign boxes.box_width   = box.box_width;
    assign boxes.box_height  = box.box_height;
    assign boxes.confidence  = box.confidence;
    assign boxes.class_index = box.class_index;

endmodule
